### hdl/lrpe_pkg.sv
`timescale 1ns / 1ps
package lrpe_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_ACTION = 3'd0,
    CMD_LOAD_GOTO   = 3'd1,
    CMD_LOAD_RULE   = 3'd2,
    CMD_START       = 3'd3,
    CMD_TOKEN       = 3'd4
  } cmd_e;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_SHIFTED  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [1:0] AK_ERROR  = 2'd0;
  localparam logic [1:0] AK_SHIFT  = 2'd1;
  localparam logic [1:0] AK_REDUCE = 2'd2;
  localparam logic [1:0] AK_ACCEPT = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] state_row;
    logic [3:0] terminal_col;
    logic [3:0] nonterminal_col;
    logic [1:0] action_kind;
    logic [5:0] action_target;
    logic       goto_valid;
    logic [5:0] goto_state;
    logic [4:0] rule_index;
    logic [3:0] rule_lhs;
    logic [3:0] rule_length;
    logic [3:0] token;
  } item_in_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] reduced_rule;
    logic [2:0] status;
    logic [8:0] stack_depth;
    logic       last;
  } item_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_in;
    logic rd_act;
    logic rd_from;
    logic push_shift;
    logic push_goto;
    logic start;
    logic clr_red;
    logic emit;
    logic emit_red;
    logic [2:0] status;
    logic fin;
  } ctrl_t;

  // Datapath status to controller.
  typedef struct packed {
    cmd_e       cmd;
    logic       load_bad;
    logic       parsing;
    logic       tok_bad;
    logic       sp_bad;
    logic       top_bad;
    logic [1:0] akind;
    logic       tok_is_end;
    logic       full;
    logic       red_bad;
    logic       rule_bad;
    logic       from_bad;
    logic       goto_bad;
    logic       push_full;
  } stat_t;

endpackage

### hdl/lr_table_parse_engine_core.sv
`timescale 1ns / 1ps
// Table-driven LR shift-reduce parse engine. Load, start and ignored items
// finish with one result. A token item first reads the stack top and action
// table, then for each reduction steps through a rule check, a stack read at
// the pop point, a goto table read and push, and a
// fresh read of the stack top and action table, with one reduction report
// per reduction and a final status result; the latency is set by the single
// read port of the stack and table memories. After reset
// the action and goto tables are cleared in a sweep over
// max(NUM_STATES*NUM_TERMINALS, NUM_STATES*NUM_NONTERMINALS) rounded up to a
// power of two addresses (1024 by default), during which busy is high. Results
// are shown for one cycle on result_valid and the receiver cannot stall them.
module lr_table_parse_engine_core #(
  parameter int NUM_STATES       = 64,
  parameter int NUM_TERMINALS    = 16,
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_RULES        = 32,
  parameter int STACK_DEPTH      = 256,
  parameter int MAX_REDUCTIONS   = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lrpe_pkg::item_in_t  item_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  output logic                result_valid_o,
  output lrpe_pkg::item_out_t result_o
);
  import lrpe_pkg::*;

  ctrl_t      ctrl;
  stat_t      stat;
  logic [3:0] end_marker_q;
  logic       ready_q;
  logic [$clog2(NUM_STATES * ((NUM_TERMINALS > NUM_NONTERMINALS) ?
                NUM_TERMINALS : NUM_NONTERMINALS)):0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= '0;
      ready_q <= 1'b0;
      sweep_q <= '0;
    end else begin
      if (cfg_we_i) begin
        end_marker_q <= cfg_wdata_i;
      end
      if (!ready_q) begin
        sweep_q <= sweep_q + 1'b1;
        if (&sweep_q[$bits(sweep_q)-2:0]) begin
          ready_q <= 1'b1;
        end
      end
    end
  end

  lrpe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .ready_i(ready_q), .stat_i(stat), .busy, .ctrl_o(ctrl)
  );

  lrpe_datapath #(
    .NUM_STATES(NUM_STATES), .NUM_TERMINALS(NUM_TERMINALS),
    .NUM_NONTERMINALS(NUM_NONTERMINALS), .NUM_RULES(NUM_RULES),
    .STACK_DEPTH(STACK_DEPTH), .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_dp (
    .clk_i, .rst_ni, .item_i, .end_marker_i(end_marker_q), .clear_i(!ready_q),
    .ctrl_i(ctrl), .stat_o(stat), .result_valid_o, .result_o
  );
endmodule

### hdl/lrpe_ram.sv
`timescale 1ns / 1ps
module lrpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/lrpe_datapath.sv
`timescale 1ns / 1ps
module lrpe_datapath #(
  parameter int NUM_STATES       = 64,
  parameter int NUM_TERMINALS    = 16,
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_RULES        = 32,
  parameter int STACK_DEPTH      = 256,
  parameter int MAX_REDUCTIONS   = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrpe_pkg::item_in_t  item_i,
  input  logic [3:0]          end_marker_i,
  input  logic                clear_i,
  input  lrpe_pkg::ctrl_t     ctrl_i,
  output lrpe_pkg::stat_t     stat_o,
  output logic                result_valid_o,
  output lrpe_pkg::item_out_t result_o
);
  import lrpe_pkg::*;

  localparam int AW  = $clog2(NUM_STATES * NUM_TERMINALS);
  localparam int GW  = $clog2(NUM_STATES * NUM_NONTERMINALS);
  localparam int RW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int PW  = $clog2(STACK_DEPTH + 1);
  localparam int CW  = (AW > GW) ? AW : GW;

  item_in_t        in_q;
  logic [PW-1:0]   sp_q;
  logic            parsing_q;
  logic [5:0]      nred_q;
  logic [5:0]      rule_q;
  logic [CW-1:0]   clr_q;
  logic            clr_busy;
  logic [NUM_RULES-1:0] rvalid_q;
  logic [3:0]      rule_lhs_q [NUM_RULES];
  logic [3:0]      rule_len_q [NUM_RULES];
  logic            out_v_q;
  item_out_t       out_q;

  logic [5:0]  stk_rd;
  logic [7:0]  act_rd;
  logic [6:0]  goto_rd;
  logic [SW-1:0] stk_raddr, stk_waddr;
  logic [5:0]  stk_wdata;
  logic        stk_we;
  logic [AW-1:0] act_raddr, act_waddr;
  logic [GW-1:0] goto_raddr, goto_waddr;
  logic        act_we, goto_we;
  logic [7:0]  act_wdata;
  logic [6:0]  goto_wdata;
  logic [3:0]  cur_lhs, cur_len;
  logic [RW-1:0] rsel;
  logic [PW-1:0] sp_after;

  assign clr_busy = clear_i;
  assign rsel = RW'(rule_q);
  assign cur_lhs = rvalid_q[rsel] ? rule_lhs_q[rsel] : 4'd0;
  assign cur_len = rvalid_q[rsel] ? rule_len_q[rsel] : 4'd0;
  assign sp_after = sp_q - PW'(cur_len);

  always_comb begin
    stk_raddr = SW'(sp_q - PW'(1));
    if (ctrl_i.rd_from) begin
      stk_raddr = SW'(sp_q - PW'(cur_len) - PW'(1));
    end
  end

  always_comb begin
    stk_we = ctrl_i.push_shift | ctrl_i.push_goto | ctrl_i.start;
    stk_waddr = SW'(sp_q);
    stk_wdata = act_rd[5:0];
    if (ctrl_i.start) begin
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (ctrl_i.push_goto) begin
      stk_waddr = SW'(sp_after);
      stk_wdata = goto_rd[5:0];
    end
  end

  assign act_raddr  = AW'(stk_rd * NUM_TERMINALS + 32'(in_q.token));
  assign goto_raddr = GW'(stk_rd * NUM_NONTERMINALS + 32'(cur_lhs));

  always_comb begin
    act_we = 1'b0;
    goto_we = 1'b0;
    act_waddr = AW'(clr_q);
    goto_waddr = GW'(clr_q);
    act_wdata = '0;
    goto_wdata = '0;
    if (clr_busy) begin
      act_we = 1'b1;
      goto_we = 1'b1;
    end else if (ctrl_i.latch_in && !stat_o.load_bad) begin
      if (item_i.cmd == CMD_LOAD_ACTION) begin
        act_we = 1'b1;
        act_waddr = AW'(item_i.state_row * NUM_TERMINALS + 32'(item_i.terminal_col));
        act_wdata = {item_i.action_kind, item_i.action_target};
      end else if (item_i.cmd == CMD_LOAD_GOTO) begin
        goto_we = 1'b1;
        goto_waddr = GW'(item_i.state_row * NUM_NONTERMINALS + 32'(item_i.nonterminal_col));
        goto_wdata = item_i.goto_valid ? {1'b1, item_i.goto_state} : 7'd0;
      end
    end
  end

  lrpe_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );
  lrpe_ram #(.WIDTH(8), .DEPTH(2**AW)) u_action (
    .clk_i, .we_i(act_we), .waddr_i(act_waddr), .wdata_i(act_wdata),
    .raddr_i(act_raddr), .rdata_o(act_rd)
  );
  lrpe_ram #(.WIDTH(7), .DEPTH(2**GW)) u_goto (
    .clk_i, .we_i(goto_we), .waddr_i(goto_waddr), .wdata_i(goto_wdata),
    .raddr_i(goto_raddr), .rdata_o(goto_rd)
  );

  always_comb begin
    stat_o.cmd = cmd_e'(item_i.cmd);
    stat_o.load_bad = 1'b0;
    unique case (item_i.cmd)
      CMD_LOAD_ACTION: stat_o.load_bad = (32'(item_i.state_row) >= NUM_STATES) ||
                                         (32'(item_i.terminal_col) >= NUM_TERMINALS);
      CMD_LOAD_GOTO:   stat_o.load_bad = (32'(item_i.state_row) >= NUM_STATES) ||
                                         (32'(item_i.nonterminal_col) >= NUM_NONTERMINALS);
      CMD_LOAD_RULE:   stat_o.load_bad = 32'(item_i.rule_index) >= NUM_RULES;
      default:         stat_o.load_bad = 1'b0;
    endcase
    stat_o.parsing    = parsing_q;
    stat_o.tok_bad    = 32'(in_q.token) >= NUM_TERMINALS;
    stat_o.sp_bad     = (sp_q == '0) || (32'(sp_q) > STACK_DEPTH);
    stat_o.top_bad    = 32'(stk_rd) >= NUM_STATES;
    stat_o.akind      = act_rd[7:6];
    stat_o.tok_is_end = in_q.token == end_marker_i;
    stat_o.full       = 32'(sp_q) >= STACK_DEPTH;
    stat_o.red_bad    = (32'(nred_q) >= MAX_REDUCTIONS) ||
                        (32'(act_rd[5:0]) >= NUM_RULES);
    stat_o.rule_bad   = (PW'(cur_len) >= sp_q) || (32'(cur_lhs) >= NUM_NONTERMINALS);
    stat_o.from_bad   = 32'(stk_rd) >= NUM_STATES;
    stat_o.goto_bad   = !goto_rd[6];
    stat_o.push_full  = 32'(sp_after) >= STACK_DEPTH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      parsing_q <= 1'b0;
      nred_q <= '0;
      clr_q <= '0;
      rvalid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= ctrl_i.emit;
      if (clr_busy) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ctrl_i.latch_in && !stat_o.load_bad && item_i.cmd == CMD_LOAD_RULE) begin
        rvalid_q[RW'(item_i.rule_index)] <= 1'b1;
      end
      if (ctrl_i.start) begin
        sp_q <= PW'(1);
        parsing_q <= 1'b1;
      end
      if (ctrl_i.push_shift) begin
        sp_q <= sp_q + PW'(1);
      end
      if (ctrl_i.push_goto) begin
        sp_q <= sp_after + PW'(1);
        nred_q <= nred_q + 6'd1;
      end
      if (ctrl_i.clr_red) begin
        nred_q <= '0;
      end
      if (ctrl_i.fin) begin
        parsing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      in_q <= item_i;
      if (item_i.cmd == CMD_LOAD_RULE && !stat_o.load_bad) begin
        rule_lhs_q[RW'(item_i.rule_index)] <= item_i.rule_lhs;
        rule_len_q[RW'(item_i.rule_index)] <= item_i.rule_length;
      end
    end
    if (ctrl_i.rd_act) begin
      rule_q <= act_rd[5:0];
    end
    if (ctrl_i.emit) begin
      out_q.kind         <= !ctrl_i.emit_red;
      out_q.reduced_rule <= ctrl_i.emit_red ? rule_q[4:0] : 5'd0;
      out_q.status       <= ctrl_i.status;
      out_q.last         <= !ctrl_i.emit_red;
      if (ctrl_i.start) begin
        out_q.stack_depth <= 9'd1;
      end else if (ctrl_i.push_shift) begin
        out_q.stack_depth <= 9'(sp_q + PW'(1));
      end else if (ctrl_i.push_goto) begin
        out_q.stack_depth <= 9'(sp_after + PW'(1));
      end else begin
        out_q.stack_depth <= 9'(sp_q);
      end
    end
  end

  // Clearing sweep blocks item intake through the controller.
  assign result_valid_o = out_v_q;
  assign result_o = out_q;
endmodule

### hdl/lrpe_ctrl.sv
`timescale 1ns / 1ps
module lrpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            ready_i,
  input  lrpe_pkg::stat_t stat_i,
  output logic            busy,
  output lrpe_pkg::ctrl_t ctrl_o
);
  import lrpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TOP, S_ACT, S_DECIDE, S_FROM, S_GOTO, S_PUSH
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE) || !ready_i;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.status = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (start && ready_i) begin
          ctrl_o.latch_in = 1'b1;
          unique case (stat_i.cmd)
            CMD_LOAD_ACTION, CMD_LOAD_GOTO, CMD_LOAD_RULE: begin
              ctrl_o.emit = 1'b1;
              ctrl_o.status = stat_i.load_bad ? ST_IGNORED : ST_DONE;
            end
            CMD_START: begin
              ctrl_o.emit = 1'b1;
              ctrl_o.start = 1'b1;
            end
            CMD_TOKEN: begin
              if (stat_i.parsing) begin
                ctrl_o.clr_red = 1'b1;
                state_d = S_TOP;
              end else begin
                ctrl_o.emit = 1'b1;
                ctrl_o.status = ST_IGNORED;
              end
            end
            default: begin
              ctrl_o.emit = 1'b1;
              ctrl_o.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_TOP: begin
        if (stat_i.tok_bad || stat_i.sp_bad) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_REJECTED;
          state_d = S_IDLE;
        end else begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (stat_i.top_bad) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_REJECTED;
          state_d = S_IDLE;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat_i.akind)
          AK_SHIFT: begin
            ctrl_o.emit = 1'b1;
            state_d = S_IDLE;
            if (stat_i.full) begin
              ctrl_o.fin = 1'b1;
              ctrl_o.status = ST_OVERFLOW;
            end else begin
              ctrl_o.push_shift = 1'b1;
              ctrl_o.status = ST_SHIFTED;
            end
          end
          AK_REDUCE: begin
            if (stat_i.red_bad) begin
              ctrl_o.emit = 1'b1;
              ctrl_o.fin = 1'b1;
              ctrl_o.status = ST_REJECTED;
              state_d = S_IDLE;
            end else begin
              ctrl_o.rd_act = 1'b1;
              state_d = S_FROM;
            end
          end
          AK_ACCEPT: begin
            ctrl_o.emit = 1'b1;
            ctrl_o.fin = 1'b1;
            ctrl_o.status = stat_i.tok_is_end ? ST_ACCEPTED : ST_REJECTED;
            state_d = S_IDLE;
          end
          default: begin
            ctrl_o.emit = 1'b1;
            ctrl_o.fin = 1'b1;
            ctrl_o.status = ST_REJECTED;
            state_d = S_IDLE;
          end
        endcase
      end
      S_FROM: begin
        if (stat_i.rule_bad) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_REJECTED;
          state_d = S_IDLE;
        end else begin
          ctrl_o.rd_from = 1'b1;
          state_d = S_GOTO;
        end
      end
      S_GOTO: begin
        ctrl_o.rd_from = 1'b1;
        if (stat_i.from_bad) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_REJECTED;
          state_d = S_IDLE;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat_i.goto_bad) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_REJECTED;
          state_d = S_IDLE;
        end else if (stat_i.push_full) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.fin = 1'b1;
          ctrl_o.status = ST_OVERFLOW;
          state_d = S_IDLE;
        end else begin
          ctrl_o.push_goto = 1'b1;
          ctrl_o.emit = 1'b1;
          ctrl_o.emit_red = 1'b1;
          state_d = S_TOP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
